// ===== hw/rtl/srd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_pkg: shared types and constants for the stitch record decoder
// Holds the request payload structs, the record framing codes and the
// balanced ternary digit helper.
// ----------------------------------------------------------------------------
package srd_pkg;

  localparam int HEADER_BYTES_DEF = 256;

  // Third record byte that marks the end of the pattern.
  localparam logic [7:0] END_RECORD = 8'hF3;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_file;
    logic       last_of_file;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic              trim_flag;
    logic              stop_flag;
    logic              end_flag;
    logic              last_of_run;
  } out_item_t;

  // One balanced ternary digit: +1, 0 or -1.
  function automatic logic signed [7:0] trit(input logic pos, input logic neg);
    logic signed [7:0] p;
    logic signed [7:0] n;
    p = signed'({7'd0, pos});
    n = signed'({7'd0, neg});
    return p - n;
  endfunction

  // Result item of the end-of-pattern stitch.
  function automatic out_item_t end_stitch(input logic last);
    out_item_t r;
    r.move_x      = '0;
    r.move_y      = '0;
    r.trim_flag   = 1'b0;
    r.stop_flag   = 1'b0;
    r.end_flag    = 1'b1;
    r.last_of_run = last;
    return r;
  endfunction

endpackage

// ===== hw/rtl/stitch_record_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stitch_record_decoder_top: byte-serial stitch file decoder
// Skips the file header, frames three-byte records and decodes balanced
// ternary moves, trim/stop flags and the end of the pattern.
// ----------------------------------------------------------------------------
// The decoder takes one file byte per cycle and turns every third byte after
// the HEADER_BYTES header bytes into one stitch request, decoded in a single
// pass from the byte and the two held record bytes straight into the output
// register. A byte that ends the file without an end record also yields an
// end stitch, so one byte can give two requests; the second waits in a
// pending register, and the input stalls until it has been handed over.
// Otherwise the rate is one byte per cycle whenever the output side does
// not stall.
module stitch_record_decoder_top
  #(
    parameter int HEADER_BYTES = srd_pkg::HEADER_BYTES_DEF
  )
  (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  srd_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output srd_pkg::out_item_t out_data
  );

  import srd_pkg::*;

  localparam int HdrW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES + 1) : 1;

  logic [HdrW-1:0] header_count_r, header_count_nxt;
  phase_t          phase_r, phase_nxt;
  logic [7:0]      byte0_r, byte0_nxt;
  logic [7:0]      byte1_r, byte1_nxt;
  logic            end_seen_r, end_seen_nxt;

  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t pend_r, pend_nxt;
  logic      pend_valid_r, pend_valid_nxt;

  logic      in_acc;
  logic      out_take;
  logic [1:0] n_res;
  out_item_t res0;
  out_item_t res1;
  out_item_t stitch;

  logic [HdrW-1:0] hc;
  phase_t          ph;
  logic [7:0]      b0;
  logic [7:0]      b1;
  logic [7:0]      b2;
  logic            ended;

  assign in_stall  = pend_valid_r || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // State as seen by this byte, after a start-of-file restart.
  always_comb begin
    hc    = in_data.first_of_file ? '0 : header_count_r;
    ph    = in_data.first_of_file ? PH_FIRST : phase_r;
    b0    = in_data.first_of_file ? 8'd0 : byte0_r;
    b1    = in_data.first_of_file ? 8'd0 : byte1_r;
    ended = in_data.first_of_file ? 1'b0 : end_seen_r;
    b2    = in_data.data_byte;
  end

  always_comb begin
    stitch.move_x = trit(b0[0], b0[1]) + 8'sd3 * trit(b1[0], b1[1])
                  + 8'sd9 * trit(b0[2], b0[3]) + 8'sd27 * trit(b1[2], b1[3])
                  + 8'sd81 * trit(b2[2], b2[3]);
    stitch.move_y = trit(b0[7], b0[6]) + 8'sd3 * trit(b1[7], b1[6])
                  + 8'sd9 * trit(b0[5], b0[4]) + 8'sd27 * trit(b1[5], b1[4])
                  + 8'sd81 * trit(b2[5], b2[4]);
    stitch.trim_flag   = b2[7];
    stitch.stop_flag   = b2[6];
    stitch.end_flag    = 1'b0;
    stitch.last_of_run = !in_data.last_of_file;
  end

  // Framing and result selection for the byte on the input.
  always_comb begin
    header_count_nxt = hc;
    phase_nxt        = ph;
    byte0_nxt        = b0;
    byte1_nxt        = b1;
    end_seen_nxt     = ended;
    n_res            = 2'd0;
    res0             = end_stitch(1'b1);
    res1             = end_stitch(1'b1);

    if (!ended) begin
      if (hc < HdrW'(HEADER_BYTES)) begin
        header_count_nxt = hc + 1'b1;
      end else begin
        case (ph)
          PH_FIRST: begin
            byte0_nxt = b2;
            phase_nxt = PH_SECOND;
          end
          PH_SECOND: begin
            byte1_nxt = b2;
            phase_nxt = PH_THIRD;
          end
          default: begin
            phase_nxt = PH_FIRST;
            n_res     = 2'd1;
            if (b2 == END_RECORD) begin
              end_seen_nxt = 1'b1;
            end else begin
              res0 = stitch;
            end
          end
        endcase
      end

      // The file ends here: close it with an end stitch unless one was just made.
      if (in_data.last_of_file) begin
        if (!end_seen_nxt) begin
          if (n_res == 2'd0) begin
            n_res = 2'd1;
          end else begin
            n_res = 2'd2;
          end
        end
        end_seen_nxt = 1'b1;
      end
    end
  end

  // Output register with one pending slot for the second request of a byte.
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    if (in_acc) begin
      out_nxt        = res0;
      out_valid_nxt  = (n_res != 2'd0);
      pend_nxt       = res1;
      pend_valid_nxt = (n_res == 2'd2);
    end else if (out_take) begin
      out_nxt        = pend_r;
      out_valid_nxt  = pend_valid_r;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r <= '0;
      phase_r        <= PH_FIRST;
      byte0_r        <= 8'd0;
      byte1_r        <= 8'd0;
      end_seen_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      pend_valid_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        header_count_r <= header_count_nxt;
        phase_r        <= phase_nxt;
        byte0_r        <= byte0_nxt;
        byte1_r        <= byte1_nxt;
        end_seen_r     <= end_seen_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

endmodule
